@@ src/tcpu_pkg.sv @@
// Shared types, sizes and opcodes of the toy CPU execute unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tcpu_pkg;

  localparam int WORD_BITS = 16;
  localparam int REG_COUNT = 16;
  localparam int MEM_WORDS = 256;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int SH_BITS   = $clog2(WORD_BITS);
  localparam int PC_BITS   = 8;
  localparam int IMM_BITS  = 8;
  localparam int CMD_BITS  = 4;
  localparam int CYC_BITS  = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [REG_AW-1:0]    reg_addr_t;
  typedef logic [MEM_AW-1:0]    mem_addr_t;
  typedef logic [PC_BITS-1:0]   pc_t;
  typedef logic [IMM_BITS-1:0]  imm_t;
  typedef logic [CYC_BITS-1:0]  cyc_t;

  // memory word that doubles as the I/O port
  localparam mem_addr_t PORT_ADDR = mem_addr_t'(MEM_WORDS - 1);
  localparam word_t     PORT_WORD = word_t'(MEM_WORDS - 1);
  // jal links into this register
  localparam reg_addr_t LINK_REG  = reg_addr_t'(REG_COUNT - 1);

  typedef enum logic [CMD_BITS-1:0] {
    OP_HALT   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_AND    = 4'd3,
    OP_XOR    = 4'd4,
    OP_SHL    = 4'd5,
    OP_SHR    = 4'd6,
    OP_LDA    = 4'd7,
    OP_LOAD   = 4'd8,
    OP_STORE  = 4'd9,
    OP_LOADI  = 4'd10,
    OP_STOREI = 4'd11,
    OP_JZER   = 4'd12,
    OP_JPOS   = 4'd13,
    OP_JREG   = 4'd14,
    OP_JAL    = 4'd15
  } op_e;

endpackage

`default_nettype wire

@@ src/tcpu_in_if.sv @@
// Request channel of the toy CPU execute unit: one decoded instruction.
// Depends on tcpu_pkg.
`default_nettype none

interface tcpu_in_if import tcpu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  reg_addr_t           dest_reg;
  reg_addr_t           src_a_reg;
  reg_addr_t           src_b_reg;
  imm_t                immediate;
  word_t               io_in;

  modport source (
    output valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate, io_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, dest_reg, src_a_reg, src_b_reg, immediate, io_in,
    output ready
  );
endinterface

`default_nettype wire

@@ src/tcpu_out_if.sv @@
// Result channel of the toy CPU execute unit: one result per instruction.
// Depends on tcpu_pkg.
`default_nettype none

interface tcpu_out_if import tcpu_pkg::*; ();
  logic  valid;
  logic  ready;
  pc_t   next_pc;
  logic  reg_written;
  word_t written_value;
  logic  io_in_taken;
  logic  io_out_valid;
  word_t io_out_data;
  logic  halted;
  cyc_t  cycles;

  modport source (
    output valid, next_pc, reg_written, written_value, io_in_taken,
           io_out_valid, io_out_data, halted, cycles,
    input  ready
  );
  modport sink (
    input  valid, next_pc, reg_written, written_value, io_in_taken,
           io_out_valid, io_out_data, halted, cycles,
    output ready
  );
endinterface

`default_nettype wire

@@ src/toy_cpu_execute_unit.sv @@
// Top level of the toy CPU execute unit: register file, data memory, pipeline.
// Depends on tcpu_pkg, tcpu_in_if, tcpu_out_if and tcpu_alu.
`default_nettype none

// Executes one decoded instruction per request against 16 registers, a
// 256-word data memory, the PC, a 32-bit cycle count and a halt flag, and
// returns one result per request in order. Throughput: one instruction per
// clock when the result side keeps up; a new request is taken while the
// previous ones are still in flight and while a finished result waits.
// Flow: the accept edge reads the register file (two read ports, data
// registered); the execute cycle resolves operands, runs the ALU and branch,
// and issues the data memory read or write (one port each, read data
// registered); the memory cycle completes loads and writes the register file;
// a result register then holds the answer until it is taken. The longest path
// runs from the data memory read data through operand forwarding into the
// next memory address. Register file starts all zero through per-entry
// valid bits, so no clearing pass is needed; data memory is not initialized
// and a read of a never-written word returns whatever the RAM holds.
// Address 255 is the I/O port: a load from it stores io_in there and returns
// it; a store to it emits the word. Once halt executes, later requests
// return the frozen PC and cycle count with halted set and nothing written.

module toy_cpu_execute_unit import tcpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpu_in_if.sink     req_i,
  tcpu_out_if.source  rsp_o
);

  // ---------------------------------------------------------------------
  // Pipeline handshakes
  // ---------------------------------------------------------------------
  logic e_valid_q, m_valid_q, out_valid_q;
  logic m_done, e_adv, in_fire;

  // M retires when the result register is free or being emptied
  assign m_done  = m_valid_q && (!out_valid_q || rsp_o.ready);
  // E moves whenever M is empty or retiring
  assign e_adv   = !m_valid_q || m_done;
  assign req_i.ready = !e_valid_q || e_adv;
  assign in_fire = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------
  // Register file: 2 read ports, 1 write port, valid bits for reset-to-zero
  // ---------------------------------------------------------------------
  word_t                rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid_q;
  word_t                rf_rdata_a_q, rf_rdata_b_q;
  logic                 rf_rvld_a_q, rf_rvld_b_q;
  reg_addr_t            rd_addr_a;
  logic                 rf_we;
  reg_addr_t            rf_waddr;
  word_t                rf_wdata;
  op_e                  in_op;

  assign in_op = op_e'(req_i.cmd);

  // port A reads the stored/tested register for stores and for every jump but jal
  always_comb begin
    unique case (in_op)
      OP_STORE, OP_STOREI, OP_JZER, OP_JPOS, OP_JREG: rd_addr_a = req_i.dest_reg;
      default:                                        rd_addr_a = req_i.src_a_reg;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rf_rdata_a_q <= rf_mem[rd_addr_a];
      rf_rdata_b_q <= rf_mem[req_i.src_b_reg];
      rf_rvld_a_q  <= rf_valid_q[rd_addr_a];
      rf_rvld_b_q  <= rf_valid_q[req_i.src_b_reg];
    end
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
  end

  // last write, kept for the read that coincides with it
  logic      lw_valid_q;
  reg_addr_t lw_addr_q;
  word_t     lw_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      lw_valid_q <= 1'b0;
    end else if (rf_we) begin
      rf_valid_q[rf_waddr] <= 1'b1;
      lw_valid_q           <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      lw_addr_q <= rf_waddr;
      lw_data_q <= rf_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Execute stage registers
  // ---------------------------------------------------------------------
  op_e       e_op_q;
  reg_addr_t e_rd_q, e_addr_a_q, e_addr_b_q;
  imm_t      e_imm_q;
  word_t     e_io_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_op_q     <= in_op;
      e_rd_q     <= req_i.dest_reg;
      e_addr_a_q <= rd_addr_a;
      e_addr_b_q <= req_i.src_b_reg;
      e_imm_q    <= req_i.immediate;
      e_io_q     <= req_i.io_in;
    end
  end

  // ---------------------------------------------------------------------
  // Memory stage registers and its final value
  // ---------------------------------------------------------------------
  logic      m_wr_q, m_load_q, m_taken_q, m_outv_q, m_halted_q;
  reg_addr_t m_rd_q;
  word_t     m_wval_q, m_io_q, m_odata_q;
  pc_t       m_pc_q;
  cyc_t      m_cycles_q;
  word_t     dm_rdata_q;
  word_t     m_value;

  // port reads return the io word directly
  assign m_value = m_load_q ? (m_taken_q ? m_io_q : dm_rdata_q) : m_wval_q;

  assign rf_we    = m_done && m_wr_q;
  assign rf_waddr = m_rd_q;
  assign rf_wdata = m_value;

  // ---------------------------------------------------------------------
  // Operand forwarding: M stage first, then the last write, then the RAM
  // ---------------------------------------------------------------------
  word_t op_a, op_b;

  always_comb begin
    priority if (m_valid_q && m_wr_q && (m_rd_q == e_addr_a_q)) begin
      op_a = m_value;
    end else if (lw_valid_q && (lw_addr_q == e_addr_a_q)) begin
      op_a = lw_data_q;
    end else begin
      op_a = rf_rvld_a_q ? rf_rdata_a_q : '0;
    end
  end

  always_comb begin
    priority if (m_valid_q && m_wr_q && (m_rd_q == e_addr_b_q)) begin
      op_b = m_value;
    end else if (lw_valid_q && (lw_addr_q == e_addr_b_q)) begin
      op_b = lw_data_q;
    end else begin
      op_b = rf_rvld_b_q ? rf_rdata_b_q : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------------
  pc_t   pc_q;
  cyc_t  cycles_q;
  logic  halt_q;
  word_t alu_res;

  tcpu_alu u_alu (
    .op_i  (e_op_q),
    .a_i   (op_a),
    .b_i   (op_b),
    .imm_i (e_imm_q),
    .res_o (alu_res)
  );

  pc_t       pc_inc, e_npc;
  logic [1:0] e_cost;
  logic      e_wr, e_load, e_taken, e_outv, e_halt;
  reg_addr_t e_waddr;
  word_t     e_wval, e_odata;
  logic      dm_we, dm_re;
  mem_addr_t dm_waddr, dm_raddr;
  word_t     dm_wdata;

  assign pc_inc = pc_q + pc_t'(1);

  always_comb begin
    e_npc    = pc_inc;
    e_cost   = 2'd1;
    e_wr     = 1'b0;
    e_load   = 1'b0;
    e_taken  = 1'b0;
    e_outv   = 1'b0;
    e_halt   = halt_q;
    e_waddr  = e_rd_q;
    e_wval   = '0;
    e_odata  = '0;
    dm_we    = 1'b0;
    dm_re    = 1'b0;
    dm_waddr = e_imm_q;
    dm_raddr = e_imm_q;
    dm_wdata = op_a;
    if (halt_q) begin
      // frozen: report state, touch nothing
      e_npc  = pc_q;
      e_cost = 2'd0;
    end else begin
      unique case (e_op_q)
        OP_HALT: e_halt = 1'b1;
        OP_ADD, OP_SUB, OP_AND, OP_XOR, OP_SHL, OP_SHR, OP_LDA: begin
          e_wr   = 1'b1;
          e_wval = alu_res;
        end
        OP_LOAD: begin
          e_wr    = 1'b1;
          e_load  = 1'b1;
          e_taken = (e_imm_q == PORT_ADDR);
          dm_re   = !e_taken;
          dm_we   = e_taken;
          dm_waddr = PORT_ADDR;
          dm_wdata = e_io_q;
        end
        OP_STORE: begin
          dm_we   = 1'b1;
          e_outv  = (e_imm_q == PORT_ADDR);
          e_odata = e_outv ? op_a : '0;
        end
        OP_LOADI: begin
          e_wr     = 1'b1;
          e_load   = 1'b1;
          // only the exact word 255 is the port
          e_taken  = (op_b == PORT_WORD);
          dm_re    = !e_taken;
          dm_raddr = op_b[MEM_AW-1:0];
          dm_we    = e_taken;
          dm_waddr = PORT_ADDR;
          dm_wdata = e_io_q;
        end
        OP_STOREI: begin
          dm_we    = 1'b1;
          dm_waddr = op_b[MEM_AW-1:0];
          e_outv   = (op_b == PORT_WORD);
          e_odata  = e_outv ? op_a : '0;
        end
        OP_JZER: begin
          e_cost = 2'd2;
          if (op_a == '0) e_npc = e_imm_q;
        end
        OP_JPOS: begin
          e_cost = 2'd2;
          if ((op_a != '0) && !op_a[WORD_BITS-1]) e_npc = e_imm_q;
        end
        OP_JREG: begin
          e_cost = 2'd2;
          e_npc  = op_a[PC_BITS-1:0];
        end
        OP_JAL: begin
          e_cost  = 2'd2;
          e_wr    = 1'b1;
          e_waddr = LINK_REG;
          e_wval  = {{(WORD_BITS-PC_BITS){1'b0}}, pc_inc};
          e_npc   = e_imm_q;
        end
      endcase
    end
  end

  logic e_go;
  cyc_t cycles_d;

  assign e_go     = e_valid_q && e_adv;
  assign cycles_d = cycles_q + cyc_t'(e_cost);

  // architectural state advances as each instruction leaves execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      cycles_q <= '0;
      halt_q   <= 1'b0;
    end else if (e_go) begin
      pc_q     <= e_npc;
      cycles_q <= cycles_d;
      halt_q   <= e_halt;
    end
  end

  // ---------------------------------------------------------------------
  // Data memory: one write and one registered read port
  // ---------------------------------------------------------------------
  word_t dm_mem [MEM_WORDS];

  always_ff @(posedge clk_i) begin
    if (e_go && dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (e_go && dm_re) begin
      dm_rdata_q <= dm_mem[dm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_go) begin
      m_wr_q     <= e_wr;
      m_load_q   <= e_load;
      m_taken_q  <= e_taken;
      m_outv_q   <= e_outv;
      m_halted_q <= e_halt;
      m_rd_q     <= e_waddr;
      m_wval_q   <= e_wval;
      m_io_q     <= e_io_q;
      m_odata_q  <= e_odata;
      m_pc_q     <= e_npc;
      m_cycles_q <= cycles_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage valids and result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (e_adv) begin
        e_valid_q <= in_fire;
        m_valid_q <= e_valid_q;
      end else if (in_fire) begin
        e_valid_q <= 1'b1;
      end
      if (m_done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  pc_t   out_pc_q;
  logic  out_wr_q, out_taken_q, out_outv_q, out_halted_q;
  word_t out_wval_q, out_odata_q;
  cyc_t  out_cycles_q;

  always_ff @(posedge clk_i) begin
    if (m_done) begin
      out_pc_q     <= m_pc_q;
      out_wr_q     <= m_wr_q;
      out_wval_q   <= m_wr_q ? m_value : '0;
      out_taken_q  <= m_taken_q;
      out_outv_q   <= m_outv_q;
      out_odata_q  <= m_odata_q;
      out_halted_q <= m_halted_q;
      out_cycles_q <= m_cycles_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.next_pc       = out_pc_q;
  assign rsp_o.reg_written   = out_wr_q;
  assign rsp_o.written_value = out_wval_q;
  assign rsp_o.io_in_taken   = out_taken_q;
  assign rsp_o.io_out_valid  = out_outv_q;
  assign rsp_o.io_out_data   = out_odata_q;
  assign rsp_o.halted        = out_halted_q;
  assign rsp_o.cycles        = out_cycles_q;

endmodule

`default_nettype wire

@@ src/tcpu_alu.sv @@
// Register-to-register datapath of the toy CPU: add, sub, and, xor, shifts, lda.
// Depends on tcpu_pkg.
`default_nettype none

module tcpu_alu import tcpu_pkg::*; (
  input  op_e   op_i,
  input  word_t a_i,
  input  word_t b_i,
  input  imm_t  imm_i,
  output word_t res_o
);

  logic sh_over;

  // counts of a word or more clear everything
  assign sh_over = (b_i >= word_t'(WORD_BITS));

  always_comb begin
    unique case (op_i)
      OP_ADD:  res_o = a_i + b_i;
      OP_SUB:  res_o = a_i - b_i;
      OP_AND:  res_o = a_i & b_i;
      OP_XOR:  res_o = a_i ^ b_i;
      OP_SHL:  res_o = sh_over ? '0 : (a_i << b_i[SH_BITS-1:0]);
      OP_SHR:  res_o = sh_over ? '0 : (a_i >> b_i[SH_BITS-1:0]);
      OP_LDA:  res_o = {{(WORD_BITS-IMM_BITS){1'b0}}, imm_i};
      default: res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/tcpu_checker.sv @@
// Port-level checks for the toy CPU execute unit, bound to the top level.
// Depends on tcpu_pkg and toy_cpu_execute_unit.
`default_nettype none

module tcpu_checker import tcpu_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic halted_i,
  input logic reg_written_i,
  input logic io_in_taken_i,
  input logic io_out_valid_i,
  input cyc_t cycles_i
);

  logic       in_acc, out_acc;
  logic [2:0] pending_q;
  logic       seen_halt_q, have_last_q;
  cyc_t       last_cyc_q, cyc_delta;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_acc   = out_valid_i && out_ready_i;
  assign cyc_delta = cycles_i - last_cyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      seen_halt_q <= 1'b0;
      have_last_q <= 1'b0;
      last_cyc_q  <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc) begin
        seen_halt_q <= seen_halt_q || halted_i;
        have_last_q <= 1'b1;
        last_cyc_q  <= cycles_i;
      end
    end
  end

  // no result without an outstanding request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != '0))
    else $error("result offered with no request outstanding");

  // halt is sticky across results
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && seen_halt_q) |-> halted_i)
    else $error("halted dropped after a halt");

  // a halted machine writes nothing and moves no port data
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && halted_i) |-> (!reg_written_i && !io_in_taken_i && !io_out_valid_i))
    else $error("side effect reported while halted");

  // cycle count steps by 1 or 2, or stands still once halted
  a_cyc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && have_last_q) |->
      ((cyc_delta == cyc_t'(1)) || (cyc_delta == cyc_t'(2)) ||
       (halted_i && (cyc_delta == '0))))
    else $error("cycle count stepped by an illegal amount");

endmodule

bind toy_cpu_execute_unit tcpu_checker u_tcpu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .halted_i       (rsp_o.halted),
  .reg_written_i  (rsp_o.reg_written),
  .io_in_taken_i  (rsp_o.io_in_taken),
  .io_out_valid_i (rsp_o.io_out_valid),
  .cycles_i       (rsp_o.cycles)
);

`default_nettype wire
